FILE: hw/rtl/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_FETCH   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_CONTROL = 2'd0,
      REG_LEVEL   = 2'd1,
      REG_ADDRESS = 2'd2,
      REG_LENGTH  = 2'd3
   } reg_sel_type;

   typedef struct packed {
      kind_type    kind;
      reg_sel_type reg_index;
      logic [7:0]  write_data;
      logic [7:0]  fetch_data;
   } item_type;

   typedef struct packed {
      logic [6:0]  output_level;
      logic        irq_pending;
      logic        fetch_request;
      logic [15:0] fetch_address;
   } result_type;

   localparam logic [15:0] RESET_ADDR    = 16'hC000;
   localparam logic [15:0] WRAP_ADDR     = 16'h8000;
   localparam logic [6:0]  LEVEL_UP_MAX  = 7'd125;
   localparam logic [6:0]  LEVEL_STEP    = 7'd2;
   localparam logic [8:0]  RATE_RESET    = 9'd428;
   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
   localparam logic [11:0] LENGTH_RESET  = 12'd1;

   function automatic logic [8:0] rate_lookup(input logic [3:0] idx);
      logic [8:0] r;
      case (idx)
         4'd0:    r = 9'd428;
         4'd1:    r = 9'd380;
         4'd2:    r = 9'd340;
         4'd3:    r = 9'd320;
         4'd4:    r = 9'd286;
         4'd5:    r = 9'd254;
         4'd6:    r = 9'd226;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd190;
         4'd9:    r = 9'd160;
         4'd10:   r = 9'd142;
         4'd11:   r = 9'd128;
         4'd12:   r = 9'd106;
         4'd13:   r = 9'd84;
         4'd14:   r = 9'd72;
         default: r = 9'd54;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/dsc_core.sv
`timescale 1ns / 1ps

module dsc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  dsc_pkg::item_type   item,
   output dsc_pkg::result_type result
);

   logic [8:0]  rate_counter_ff,  rate_counter_in;
   logic [8:0]  rate_reload_ff,   rate_reload_in;
   logic [6:0]  level_ff,         level_in;
   logic [7:0]  shifter_ff,       shifter_in;
   logic [3:0]  bits_left_ff,     bits_left_in;
   logic        silent_ff,        silent_in;
   logic [7:0]  held_byte_ff,     held_byte_in;
   logic        held_empty_ff,    held_empty_in;
   logic [15:0] read_ptr_ff,      read_ptr_in;
   logic [11:0] bytes_left_ff,    bytes_left_in;
   logic [15:0] start_addr_ff,    start_addr_in;
   logic [11:0] length_ff,        length_in;
   logic        irq_on_ff,        irq_on_in;
   logic        irq_flag_ff,      irq_flag_in;
   logic        loop_on_ff,       loop_on_in;

   logic        do_fetch;
   logic [15:0] fetch_addr;
   logic [15:0] ptr_inc;
   logic [11:0] count_dec;

   always_comb begin
      rate_counter_in = rate_counter_ff;
      rate_reload_in  = rate_reload_ff;
      level_in        = level_ff;
      shifter_in      = shifter_ff;
      bits_left_in    = bits_left_ff;
      silent_in       = silent_ff;
      held_byte_in    = held_byte_ff;
      held_empty_in   = held_empty_ff;
      read_ptr_in     = read_ptr_ff;
      bytes_left_in   = bytes_left_ff;
      start_addr_in   = start_addr_ff;
      length_in       = length_ff;
      irq_on_in       = irq_on_ff;
      irq_flag_in     = irq_flag_ff;
      loop_on_in      = loop_on_ff;
      do_fetch        = 1'b0;
      fetch_addr      = 16'd0;
      ptr_inc         = 16'd0;
      count_dec       = 12'd0;

      case (item.kind)
         dsc_pkg::KIND_WRITE: begin
            case (item.reg_index)
               dsc_pkg::REG_CONTROL: begin
                  irq_on_in = item.write_data[7];
                  if (!item.write_data[7]) begin
                     irq_flag_in = 1'b0;
                  end
                  loop_on_in     = item.write_data[6];
                  rate_reload_in = dsc_pkg::rate_lookup(item.write_data[3:0]);
               end
               dsc_pkg::REG_LEVEL:   level_in = item.write_data[6:0];
               dsc_pkg::REG_ADDRESS: start_addr_in = {2'b11, item.write_data, 6'd0};
               default:              length_in = {item.write_data, 4'd0} + 12'd1;
            endcase
         end
         dsc_pkg::KIND_TICK: begin
            if (rate_counter_ff != 9'd0) begin
               rate_counter_in = rate_counter_ff - 9'd1;
            end else begin
               rate_counter_in = rate_reload_ff;
               if (!silent_ff) begin
                  if (shifter_ff[0]) begin
                     if (level_ff <= dsc_pkg::LEVEL_UP_MAX) begin
                        level_in = level_ff + dsc_pkg::LEVEL_STEP;
                     end
                  end else if (level_ff >= dsc_pkg::LEVEL_STEP) begin
                     level_in = level_ff - dsc_pkg::LEVEL_STEP;
                  end
               end
               shifter_in   = {1'b0, shifter_ff[7:1]};
               bits_left_in = bits_left_ff - 4'd1;
               if (bits_left_in == 4'd0) begin
                  bits_left_in = dsc_pkg::BITS_PER_BYTE;
                  if (held_empty_ff) begin
                     silent_in = 1'b1;
                  end else begin
                     silent_in     = 1'b0;
                     shifter_in    = held_byte_ff;
                     held_empty_in = 1'b1;
                     do_fetch      = (bytes_left_ff != 12'd0);
                  end
               end
            end
         end
         dsc_pkg::KIND_RESTART: begin
            read_ptr_in   = start_addr_ff;
            bytes_left_in = length_ff;
            do_fetch      = held_empty_ff && (length_ff != 12'd0);
         end
         default: begin
            held_byte_in  = item.fetch_data;
            held_empty_in = 1'b0;
         end
      endcase

      // fetch bookkeeping: advance pointer (wrapping into the upper half), count down
      if (do_fetch) begin
         fetch_addr  = read_ptr_in;
         ptr_inc     = read_ptr_in + 16'd1;
         read_ptr_in = (ptr_inc == 16'd0) ? dsc_pkg::WRAP_ADDR : ptr_inc;
         count_dec     = bytes_left_in - 12'd1;
         bytes_left_in = count_dec;
         if (count_dec == 12'd0) begin
            if (loop_on_in) begin
               read_ptr_in   = start_addr_in;
               bytes_left_in = length_in;
            end else if (irq_on_in) begin
               irq_flag_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.output_level  = level_in;
      result.irq_pending   = irq_flag_in;
      result.fetch_request = do_fetch;
      result.fetch_address = fetch_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_counter_ff <= 9'd0;
         rate_reload_ff  <= dsc_pkg::RATE_RESET;
         level_ff        <= 7'd0;
         shifter_ff      <= 8'd0;
         bits_left_ff    <= dsc_pkg::BITS_PER_BYTE;
         silent_ff       <= 1'b1;
         held_byte_ff    <= 8'd0;
         held_empty_ff   <= 1'b1;
         read_ptr_ff     <= dsc_pkg::RESET_ADDR;
         bytes_left_ff   <= 12'd0;
         start_addr_ff   <= dsc_pkg::RESET_ADDR;
         length_ff       <= dsc_pkg::LENGTH_RESET;
         irq_on_ff       <= 1'b0;
         irq_flag_ff     <= 1'b0;
         loop_on_ff      <= 1'b0;
      end else if (step) begin
         rate_counter_ff <= rate_counter_in;
         rate_reload_ff  <= rate_reload_in;
         level_ff        <= level_in;
         shifter_ff      <= shifter_in;
         bits_left_ff    <= bits_left_in;
         silent_ff       <= silent_in;
         held_byte_ff    <= held_byte_in;
         held_empty_ff   <= held_empty_in;
         read_ptr_ff     <= read_ptr_in;
         bytes_left_ff   <= bytes_left_in;
         start_addr_ff   <= start_addr_in;
         length_ff       <= length_in;
         irq_on_ff       <= irq_on_in;
         irq_flag_ff     <= irq_flag_in;
         loop_on_ff      <= loop_on_in;
      end
   end

   // the bit counter only ever holds one through eight
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      (bits_left_ff != 4'd0) && (bits_left_ff <= dsc_pkg::BITS_PER_BYTE))
      else $error("bit counter out of range");

   // sample pointer stays in the upper half of the address space
   a_ptr_upper: assert property (@(posedge clock) disable iff (reset)
      read_ptr_ff[15] && start_addr_ff[15])
      else $error("sample pointer left upper half");

   // irq flag can only be pending while irq is enabled
   a_irq_enabled: assert property (@(posedge clock) disable iff (reset)
      irq_flag_ff |-> irq_on_ff)
      else $error("irq pending with irq disabled");

endmodule

FILE: hw/rtl/delta_sample_channel.sv
`timescale 1ns / 1ps

// Delta-modulation sample channel. Takes one beat per cycle, sustained while the
// output side is not stalled: every beat (register write, timer tick, restart,
// returned sample byte) is registered on input in the input register, applied to the
// channel state combinationally, and its result beat is registered in the result
// register and held there while the output side is stalled. A fetch
// request in a result beat asks for the byte at fetch_address; its data must
// come back as a fetched-byte beat before the tick that shifts it in.
module delta_sample_channel (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] write_data, [15:8] fetch_data
   input  logic [3:0]  req_tuser,   // [1:0] req_type, [3:2] reg_index

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [6:0] output_level, [7] irq_pending, [23:8] fetch_address
   output logic        rsp_tuser    // [0] fetch_request
);

   logic                in_valid_ff;
   dsc_pkg::item_type   in_item_ff;
   logic                out_valid_ff;
   dsc_pkg::result_type out_result_ff;
   dsc_pkg::result_type next_result;
   logic                advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.kind       <= dsc_pkg::kind_type'(req_tuser[1:0]);
         in_item_ff.reg_index  <= dsc_pkg::reg_sel_type'(req_tuser[3:2]);
         in_item_ff.write_data <= req_tdata[7:0];
         in_item_ff.fetch_data <= req_tdata[15:8];
      end
   end

   dsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (next_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= next_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.fetch_address, out_result_ff.irq_pending,
                        out_result_ff.output_level};
   assign rsp_tuser  = out_result_ff.fetch_request;

   // an empty input register never refuses a beat
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");

   // no address without a request
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[23:8] == 16'd0))
      else $error("fetch address without request");

   // a requested address is always in the sample region
   a_addr_region: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata[23])
      else $error("fetch address below sample region");

endmodule
